@@ src/cdda_pkg.sv @@
// Shared types, constants and calendar tables for the date arithmetic unit.
// No dependencies; used by cdda_cal_unit and calendar_date_day_arithmetic_unit.
package cdda_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DOY_W   = 9;
    localparam int CNT_IN_W = 16;

    // limits of the supported calendar range
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_400_LIMIT = 14'd9599;
    localparam logic [YEAR_W-1:0]  YEAR_400_FLOOR = 14'd400;
    localparam logic [YEAR_W-1:0]  YEARS_PER_CYCLE = 14'd400;
    localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;

    // days in one 400-year Gregorian cycle
    localparam int CYCLE_DAYS = 146097;

    // reciprocal for division by 100 on a 14-bit year: (y * 5243) >> 19
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          DIV100_PROD_W = YEAR_W + 13;
    localparam int          CENT_W = 8;

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TODAY_YEAR  = 2'd0;
    localparam logic [1:0] CFG_TODAY_MONTH = 2'd1;
    localparam logic [1:0] CFG_TODAY_DAY   = 2'd2;

    // calendar facts for one year / month pair
    typedef struct packed {
        logic             leap;
        logic [DAY_W-1:0] mdays;
        logic [DOY_W-1:0] ydays;
    } t_cal_info;

    // length of a month, February follows the leap flag
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in a common year before the first of a month
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

@@ src/cdda_cal_unit.sv @@
// Calendar unit: leap-year test, month length and year length for one year.
// Depends on cdda_pkg.
module cdda_cal_unit
    import cdda_pkg::*;
(
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output t_cal_info          o_info
);

    logic [DIV100_PROD_W-1:0] prod;
    logic [CENT_W-1:0]        cent;
    logic [YEAR_W-1:0]        rem;
    logic                     leap;

    // split the year into centuries and remainder by reciprocal multiply
    assign prod = DIV100_PROD_W'(i_year) * DIV100_PROD_W'(DIV100_MUL);
    assign cent = prod[DIV100_SHIFT +: CENT_W];
    assign rem  = i_year - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));

    // divisible by 4 and not by 100, or divisible by 400
    assign leap = (i_year[1:0] == 2'd0) && ((rem != '0) || (cent[1:0] == 2'd0));

    assign o_info.leap  = leap;
    assign o_info.mdays = month_len(i_month, leap);
    assign o_info.ydays = leap ? 9'd366 : 9'd365;

endmodule

@@ src/calendar_date_day_arithmetic_unit.sv @@
// Gregorian date unit: holds a date and loads it or moves it by a day count.
// Sequence: an unused mode goes straight to the result; a load is checked and, if
// rejected, replaced by the clamped today date; add/subtract forms the day of year, walks
// years (up to 180) and then months (up to 11) through the shared calendar unit, or stops when it saturates.
// One item at a time; the next is accepted the cycle after its result enters the output
// register. Reset: held and today dates go to 2000-01-01, no beat pending.
module calendar_date_day_arithmetic_unit
    import cdda_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // load_year[13:0], load_month[17:14], load_day[22:18], day_count[38:23]
    input  logic [39:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // result beats
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // date_year[13:0], date_month[17:14], date_day[22:18]
    output logic [23:0] o_m_axis_tdata,
    // load_rejected[0], range_error[1]
    output logic [1:0]  o_m_axis_tuser,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    localparam int CW = (COUNT_BITS < CNT_IN_W) ? COUNT_BITS : CNT_IN_W;
    localparam int SW = ((CW > 18) ? CW : 18) + 2;
    localparam logic signed [SW-1:0] CYC     = SW'(CYCLE_DAYS);
    localparam logic signed [SW-1:0] NEG_CYC = -SW'(CYCLE_DAYS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SUBST = 3'd2;
    localparam logic [2:0] ST_DOY   = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [YEAR_W-1:0]       r_ty, n_ty;
    logic [MONTH_W-1:0]      r_tm, n_tm;
    logic [DAY_W-1:0]        r_td, n_td;
    logic [YEAR_W-1:0]       r_hy, n_hy;
    logic [MONTH_W-1:0]      r_hm, n_hm;
    logic [DAY_W-1:0]        r_hd, n_hd;
    logic [1:0]              r_mode, n_mode;
    logic [YEAR_W-1:0]       r_ly, n_ly;
    logic [MONTH_W-1:0]      r_lm, n_lm;
    logic [DAY_W-1:0]        r_ld, n_ld;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [YEAR_W-1:0]       r_y, n_y;
    logic [MONTH_W-1:0]      r_m, n_m;
    logic signed [SW-1:0]    r_s, n_s;
    logic                    r_rej, n_rej;
    logic                    r_rng, n_rng;
    logic                    r_out_valid, n_out_valid;
    logic [YEAR_W-1:0]       r_out_y, n_out_y;
    logic [MONTH_W-1:0]      r_out_m, n_out_m;
    logic [DAY_W-1:0]        r_out_d, n_out_d;
    logic                    r_out_rej, n_out_rej;
    logic                    r_out_rng, n_out_rng;

    logic [YEAR_W-1:0]       cal_year;
    logic [MONTH_W-1:0]      cal_month;
    t_cal_info               cal;
    logic                    s_neg;
    logic signed [SW-1:0]    ylen_s;
    logic signed [SW-1:0]    mlen_s;
    logic [DOY_W-1:0]        doy;
    logic                    load_ok;
    logic                    in_fire;

    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign s_neg   = r_s[SW-1];

    // steer the shared calendar unit by state
    always_comb begin
        cal_year  = r_y;
        cal_month = r_m;
        unique case (r_state)
            ST_LOAD, ST_SUBST: begin
                cal_year  = r_ly;
                cal_month = r_lm;
            end
            ST_DOY: begin
                cal_year  = r_hy;
                cal_month = r_hm;
            end
            ST_YEAR: begin
                cal_year  = s_neg ? (r_y - YEAR_MIN) : r_y;
                cal_month = r_m;
            end
            default: begin
                cal_year  = r_y;
                cal_month = r_m;
            end
        endcase
    end

    cdda_cal_unit u_cal (
        .i_year  (cal_year),
        .i_month (cal_month),
        .o_info  (cal)
    );

    assign ylen_s = $signed(SW'(cal.ydays));
    assign mlen_s = $signed(SW'(cal.mdays));
    assign doy    = days_before(r_hm) + DOY_W'(cal.leap && (r_hm > MONTH_FEB))
                    + DOY_W'(r_hd) - DOY_W'(1);
    assign load_ok = (r_ly >= YEAR_MIN) && (r_ly <= YEAR_MAX) &&
                     (r_lm >= MONTH_MIN) && (r_lm <= MONTH_MAX) &&
                     (r_ld >= DAY_MIN) && (r_ld <= cal.mdays);

    // sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_ty        = r_ty;
        n_tm        = r_tm;
        n_td        = r_td;
        n_hy        = r_hy;
        n_hm        = r_hm;
        n_hd        = r_hd;
        n_mode      = r_mode;
        n_ly        = r_ly;
        n_lm        = r_lm;
        n_ld        = r_ld;
        n_cnt       = r_cnt;
        n_y         = r_y;
        n_m         = r_m;
        n_s         = r_s;
        n_rej       = r_rej;
        n_rng       = r_rng;
        n_out_valid = r_out_valid;
        n_out_y     = r_out_y;
        n_out_m     = r_out_m;
        n_out_d     = r_out_d;
        n_out_rej   = r_out_rej;
        n_out_rng   = r_out_rng;

        // configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TODAY_YEAR:  n_ty = i_cfg_data[YEAR_W-1:0];
                CFG_TODAY_MONTH: n_tm = i_cfg_data[MONTH_W-1:0];
                CFG_TODAY_DAY:   n_td = i_cfg_data[DAY_W-1:0];
                default: ;
            endcase
        end

        // drop the result once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_mode = i_s_axis_tuser;
                    n_ly   = i_s_axis_tdata[13:0];
                    n_lm   = i_s_axis_tdata[17:14];
                    n_ld   = i_s_axis_tdata[22:18];
                    n_cnt  = i_s_axis_tdata[23 +: CW];
                    n_rej  = 1'b0;
                    n_rng  = 1'b0;
                    case (i_s_axis_tuser)
                        MODE_LOAD:          n_state = ST_LOAD;
                        MODE_ADD, MODE_SUB: n_state = ST_DOY;
                        default:            n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: begin
                if (load_ok) begin
                    n_hy    = r_ly;
                    n_hm    = r_lm;
                    n_hd    = r_ld;
                    n_state = ST_DONE;
                end else begin
                    // swap in the clamped today date
                    n_ly    = (r_ty < YEAR_MIN) ? YEAR_MIN :
                              (r_ty > YEAR_MAX) ? YEAR_MAX : r_ty;
                    n_lm    = (r_tm < MONTH_MIN) ? MONTH_MIN :
                              (r_tm > MONTH_MAX) ? MONTH_MAX : r_tm;
                    n_ld    = r_td;
                    n_state = ST_SUBST;
                end
            end
            ST_SUBST: begin
                n_hy    = r_ly;
                n_hm    = r_lm;
                n_hd    = (r_ld < DAY_MIN) ? DAY_MIN :
                          (r_ld > cal.mdays) ? cal.mdays : r_ld;
                n_rej   = 1'b1;
                n_state = ST_DONE;
            end
            ST_DOY: begin
                // offset from 1 January of the held year
                n_y = r_hy;
                n_m = MONTH_MIN;
                if (r_mode == MODE_ADD) begin
                    n_s = $signed(SW'(doy)) + $signed(SW'(r_cnt));
                end else begin
                    n_s = $signed(SW'(doy)) - $signed(SW'(r_cnt));
                end
                n_state = ST_YEAR;
            end
            ST_YEAR: begin
                if (s_neg) begin
                    // walk back
                    if (r_s < NEG_CYC) begin
                        if (r_y <= YEAR_400_FLOOR) begin
                            n_rng = 1'b1;
                        end else begin
                            n_y = r_y - YEARS_PER_CYCLE;
                            n_s = r_s + CYC;
                        end
                    end else if (r_y == YEAR_MIN) begin
                        n_rng = 1'b1;
                    end else begin
                        n_y = r_y - YEAR_MIN;
                        n_s = r_s + ylen_s;
                    end
                    if (n_rng) begin
                        n_hy    = YEAR_MIN;
                        n_hm    = MONTH_MIN;
                        n_hd    = DAY_MIN;
                        n_state = ST_DONE;
                    end
                end else begin
                    // walk forward
                    if (r_s >= CYC) begin
                        if (r_y > YEAR_400_LIMIT) begin
                            n_rng = 1'b1;
                        end else begin
                            n_y = r_y + YEARS_PER_CYCLE;
                            n_s = r_s - CYC;
                        end
                    end else if (r_s >= ylen_s) begin
                        if (r_y == YEAR_MAX) begin
                            n_rng = 1'b1;
                        end else begin
                            n_y = r_y + YEAR_MIN;
                            n_s = r_s - ylen_s;
                        end
                    end else begin
                        n_state = ST_MONTH;
                    end
                    if (n_rng) begin
                        n_hy    = YEAR_MAX;
                        n_hm    = MONTH_MAX;
                        n_hd    = DAY_MAX;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MONTH: begin
                if ((r_m < MONTH_MAX) && (r_s >= mlen_s)) begin
                    n_s = r_s - mlen_s;
                    n_m = r_m + MONTH_MIN;
                end else begin
                    n_hy    = r_y;
                    n_hm    = r_m;
                    n_hd    = DAY_W'(r_s) + DAY_MIN;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_y     = r_hy;
                    n_out_m     = r_hm;
                    n_out_d     = r_hd;
                    n_out_rej   = r_rej;
                    n_out_rng   = r_rng;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ty        <= 14'd2000;
            r_tm        <= MONTH_MIN;
            r_td        <= DAY_MIN;
            r_hy        <= 14'd2000;
            r_hm        <= MONTH_MIN;
            r_hd        <= DAY_MIN;
            r_rej       <= 1'b0;
            r_rng       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ty        <= n_ty;
            r_tm        <= n_tm;
            r_td        <= n_td;
            r_hy        <= n_hy;
            r_hm        <= n_hm;
            r_hd        <= n_hd;
            r_rej       <= n_rej;
            r_rng       <= n_rng;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_ly      <= n_ly;
        r_lm      <= n_lm;
        r_ld      <= n_ld;
        r_cnt     <= n_cnt;
        r_y       <= n_y;
        r_m       <= n_m;
        r_s       <= n_s;
        r_out_y   <= n_out_y;
        r_out_m   <= n_out_m;
        r_out_d   <= n_out_d;
        r_out_rej <= n_out_rej;
        r_out_rng <= n_out_rng;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_d, r_out_m, r_out_y};
    assign o_m_axis_tuser  = {r_out_rng, r_out_rej};

endmodule
